FILE: sv/i2c_master_byte_engine_defines.svh
// assertion macros shared by the i2c master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/i2cm_pkg.sv
// shared types and constants of the i2c master byte engine
package i2cm_pkg;

	localparam int unsigned TIMER_W = 16;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ  = 2'd2,
		REQ_STOP  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_BIT_HALF    = 2'd0,
		CFG_EDGE_HOLD   = 2'd1,
		CFG_SETUP       = 2'd2,
		CFG_ACK_TIMEOUT = 2'd3
	} cfg_idx_t;

	localparam logic [7:0]  BIT_HALF_RST    = 8'd10;
	localparam logic [7:0]  EDGE_HOLD_RST   = 8'd30;
	localparam logic [7:0]  SETUP_RST       = 8'd2;
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'hffff;

	typedef struct packed {
		logic [7:0]  bit_half;
		logic [7:0]  edge_hold;
		logic [7:0]  setup;
		logic [15:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_ok;
	} res_t;

	// a zero tick count behaves as one tick
	function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
		return (v == '0) ? {{(TIMER_W-1){1'b0}}, 1'b1} : v;
	endfunction

endpackage

FILE: sv/i2cm_cmd_if.sv
// command channel: one tick with sampled sda and an optional command
interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] req_type;
	logic [7:0] tx_byte;
	logic       ack_value;
	logic       sda_in;

	modport source (output valid, cmd_valid, req_type, tx_byte, ack_value, sda_in,
		input ready);
	modport sink (input valid, cmd_valid, req_type, tx_byte, ack_value, sda_in,
		output ready);
endinterface

FILE: sv/i2cm_res_if.sv
// result channel: line levels and status for one tick
interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_ok;

	modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_ok, input ready);
	modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_ok, output ready);
endinterface

FILE: sv/i2cm_seq.sv
// line sequencer state and its one-tick update
module i2cm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            cmd_valid,
	input  logic [1:0]      req_type,
	input  logic [7:0]      tx_byte,
	input  logic            ack_value,
	input  logic            sda_in,
	input  i2cm_pkg::cfg_t  cfg,
	output i2cm_pkg::res_t  res_d
);
	import i2cm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_ST_A    = 4'd1,
		PH_ST_B    = 4'd2,
		PH_ST_C    = 4'd3,
		PH_WR_LO   = 4'd4,
		PH_WR_HI   = 4'd5,
		PH_AK_REL  = 4'd6,
		PH_AK_WAIT = 4'd7,
		PH_AK_HOLD = 4'd8,
		PH_AK_END  = 4'd9,
		PH_RD_LO   = 4'd10,
		PH_RD_HI   = 4'd11,
		PH_RA_LO   = 4'd12,
		PH_RA_HI   = 4'd13,
		PH_SP_A    = 4'd14,
		PH_SP_B    = 4'd15
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [3:0]           bit_cnt_q, bit_cnt_d;
	logic [TIMER_W-1:0]   timer_q, timer_d;
	logic [7:0]           shift_q, shift_d;
	logic [7:0]           rx_q, rx_d;
	logic                 ack_q, ack_d;
	logic                 scl_q, scl_d;
	logic                 sda_q, sda_d;
	logic                 oe_q, oe_d;
	logic                 ack_send_q, ack_send_d;
	logic                 done_d;

	logic [TIMER_W-1:0]   bit_ticks, edge_ticks, setup_ticks, ra_ticks;

	assign bit_ticks   = at_least_one({8'd0, cfg.bit_half});
	assign edge_ticks  = at_least_one({8'd0, cfg.edge_hold});
	assign setup_ticks = at_least_one({8'd0, cfg.setup});
	assign ra_ticks    = at_least_one({7'd0, {1'b0, cfg.setup} + {1'b0, cfg.bit_half}});

	always_comb begin
		logic [TIMER_W-1:0] dec;
		logic [3:0]         cnt_inc;
		dec        = timer_q - {{(TIMER_W-1){1'b0}}, 1'b1};
		cnt_inc    = bit_cnt_q + 4'd1;
		phase_d    = phase_q;
		bit_cnt_d  = bit_cnt_q;
		timer_d    = timer_q;
		shift_d    = shift_q;
		rx_d       = rx_q;
		ack_d      = ack_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		oe_d       = oe_q;
		ack_send_d = ack_send_q;
		done_d     = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (cmd_valid) begin
				unique case (req_t'(req_type))
					REQ_START: begin
						scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b1;
						phase_d = PH_ST_A; timer_d = edge_ticks;
					end
					REQ_WRITE: begin
						shift_d = tx_byte; bit_cnt_d = 4'd0;
						scl_d = 1'b0; sda_d = tx_byte[7]; oe_d = 1'b1;
						phase_d = PH_WR_LO; timer_d = bit_ticks;
					end
					REQ_READ: begin
						ack_send_d = ack_value; shift_d = 8'd0; bit_cnt_d = 4'd0;
						scl_d = 1'b0; sda_d = 1'b1; oe_d = 1'b0;
						phase_d = PH_RD_LO; timer_d = bit_ticks;
					end
					REQ_STOP: begin
						scl_d = 1'b0; sda_d = 1'b0; oe_d = 1'b1;
						phase_d = PH_SP_A; timer_d = edge_ticks;
					end
				endcase
			end
		end else if (phase_q == PH_AK_WAIT) begin
			if (!sda_in) begin
				phase_d = PH_AK_HOLD; timer_d = setup_ticks;
			end else begin
				timer_d = dec;
				if (dec == '0) begin
					// timeout: nack, then a stop condition
					ack_d = 1'b0;
					scl_d = 1'b0; sda_d = 1'b0; oe_d = 1'b1;
					phase_d = PH_SP_A; timer_d = edge_ticks;
				end
			end
		end else begin
			timer_d = dec;
			if (dec == '0) begin
				unique case (phase_q)
					PH_ST_A: begin
						sda_d = 1'b0; phase_d = PH_ST_B; timer_d = edge_ticks;
					end
					PH_ST_B: begin
						scl_d = 1'b0; phase_d = PH_ST_C; timer_d = edge_ticks;
					end
					PH_ST_C: begin
						phase_d = PH_IDLE; done_d = 1'b1;
					end
					PH_WR_LO: begin
						scl_d = 1'b1; phase_d = PH_WR_HI; timer_d = bit_ticks;
					end
					PH_WR_HI: begin
						shift_d = {shift_q[6:0], 1'b0};
						bit_cnt_d = cnt_inc;
						scl_d = 1'b0;
						if (cnt_inc < 4'd8) begin
							sda_d = shift_q[6]; oe_d = 1'b1;
							phase_d = PH_WR_LO; timer_d = bit_ticks;
						end else begin
							oe_d = 1'b0;
							phase_d = PH_AK_REL; timer_d = setup_ticks;
						end
					end
					PH_AK_REL: begin
						scl_d = 1'b1; phase_d = PH_AK_WAIT;
						timer_d = at_least_one(cfg.ack_timeout);
					end
					PH_AK_HOLD: begin
						scl_d = 1'b0; oe_d = 1'b1;
						phase_d = PH_AK_END; timer_d = setup_ticks;
					end
					PH_AK_END: begin
						ack_d = 1'b1; phase_d = PH_IDLE; done_d = 1'b1;
					end
					PH_RD_LO: begin
						scl_d = 1'b1; phase_d = PH_RD_HI; timer_d = bit_ticks;
					end
					PH_RD_HI: begin
						shift_d = {shift_q[6:0], sda_in};
						bit_cnt_d = cnt_inc;
						scl_d = 1'b0;
						if (cnt_inc < 4'd8) begin
							phase_d = PH_RD_LO; timer_d = bit_ticks;
						end else begin
							rx_d = {shift_q[6:0], sda_in};
							oe_d = 1'b1; sda_d = ack_send_q;
							phase_d = PH_RA_LO; timer_d = ra_ticks;
						end
					end
					PH_RA_LO: begin
						// first pass raises scl for the ack bit, second pass ends
						if (bit_cnt_q == 4'd8) begin
							bit_cnt_d = 4'd9; scl_d = 1'b1;
							phase_d = PH_RA_HI; timer_d = bit_ticks;
						end else begin
							phase_d = PH_IDLE; done_d = 1'b1;
						end
					end
					PH_RA_HI: begin
						scl_d = 1'b0; phase_d = PH_RA_LO; timer_d = bit_ticks;
					end
					PH_SP_A: begin
						scl_d = 1'b1; phase_d = PH_SP_B; timer_d = edge_ticks;
					end
					PH_SP_B: begin
						sda_d = 1'b1; phase_d = PH_IDLE; done_d = 1'b1;
					end
					PH_IDLE, PH_AK_WAIT: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_cnt_q  <= 4'd0;
			timer_q    <= '0;
			shift_q    <= 8'd0;
			rx_q       <= 8'd0;
			ack_q      <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			oe_q       <= 1'b1;
			ack_send_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			bit_cnt_q  <= bit_cnt_d;
			timer_q    <= timer_d;
			shift_q    <= shift_d;
			rx_q       <= rx_d;
			ack_q      <= ack_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			oe_q       <= oe_d;
			ack_send_q <= ack_send_d;
		end
	end

	always_comb begin
		res_d.scl_level = scl_d;
		res_d.sda_level = sda_d;
		res_d.sda_drive = oe_d;
		res_d.busy_res  = (phase_d != PH_IDLE);
		res_d.done_res  = done_d;
		res_d.rx_byte   = rx_d;
		res_d.ack_ok    = ack_d;
	end

endmodule

FILE: sv/i2c_master_byte_engine.sv
// top level of the i2c master byte engine
// Each word on req is one tick of the line clock: the sampled SDA level plus an
// optional start, write, read or stop command, taken only while no command is in
// progress. Every accepted word yields exactly one word on res with the SCL and
// SDA levels, the SDA drive enable and the command status after that tick. The
// sequencer updates once per word in a single registered step, and an output
// register holds the result, so one word is accepted every clock cycle for as
// long as res is taken; the only stall comes from res.ready. The user is to write
// timing registers on the cfg port only while idle; the block does not enforce it.
`include "i2c_master_byte_engine_defines.svh"

module i2c_master_byte_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	i2cm_cmd_if.sink    req,
	i2cm_res_if.source  res
);
	import i2cm_pkg::*;

	cfg_t  cfg_q;
	res_t  res_d;
	res_t  res_q;
	logic  out_valid_q;
	logic  in_acc;

	assign req.ready = !out_valid_q || res.ready;
	assign in_acc    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_half    <= BIT_HALF_RST;
			cfg_q.edge_hold   <= EDGE_HOLD_RST;
			cfg_q.setup       <= SETUP_RST;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BIT_HALF:    cfg_q.bit_half    <= cfg_data[7:0];
				CFG_EDGE_HOLD:   cfg_q.edge_hold   <= cfg_data[7:0];
				CFG_SETUP:       cfg_q.setup       <= cfg_data[7:0];
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data;
			endcase
		end
	end

	i2cm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_acc),
		.cmd_valid (req.cmd_valid),
		.req_type  (req.req_type),
		.tx_byte   (req.tx_byte),
		.ack_value (req.ack_value),
		.sda_in    (req.sda_in),
		.cfg       (cfg_q),
		.res_d     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_d;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.scl_level = res_q.scl_level;
	assign res.sda_level = res_q.sda_level;
	assign res.sda_drive = res_q.sda_drive;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.rx_byte   = res_q.rx_byte;
	assign res.ack_ok    = res_q.ack_ok;

	`I2CM_ASSERT_NEXT(a_acc_gives_word, clk, arst_n, in_acc, out_valid_q, "accepted tick lost")
	`I2CM_ASSERT_NOW(a_done_not_busy, clk, arst_n, out_valid_q && res_q.done_res,
		!res_q.busy_res, "done while still busy")
	`I2CM_ASSERT_NOW(a_release_only_busy, clk, arst_n, out_valid_q && !res_q.sda_drive,
		res_q.busy_res, "sda released while idle")

endmodule

FILE: verif/tb_top.sv
// testbench of the i2c master byte engine: tick-by-tick line prediction with random flow control
`timescale 1ns / 100ps

module tb_top;
	import i2cm_pkg::*;

	typedef enum logic [3:0] {
		LN_IDLE, LN_START_A, LN_START_B, LN_START_C,
		LN_WR_LO, LN_WR_HI, LN_ACK_REL, LN_ACK_WAIT, LN_ACK_HOLD, LN_ACK_END,
		LN_RD_LO, LN_RD_HI, LN_RACK_LO, LN_RACK_HI, LN_STOP_A, LN_STOP_B
	} ln_phase_t;

	typedef struct packed {
		logic       cmd_valid;
		req_t       req_type;
		logic [7:0] tx_byte;
		logic       ack_value;
		logic       sda_in;
	} tick_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	i2cm_cmd_if cmd_ch();
	i2cm_res_if res_ch();

	i2c_master_byte_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (cmd_ch),
		.res       (res_ch)
	);

	// timing copy and line sequencer state of the predictor
	logic [15:0] cf_bit_half;
	logic [15:0] cf_edge_hold;
	logic [15:0] cf_setup;
	logic [15:0] cf_ack_timeout;

	ln_phase_t   ln_phase;
	logic [3:0]  ln_bits;
	logic [15:0] ln_timer;
	logic [7:0]  ln_shift;
	logic [7:0]  ln_rx;
	logic        ln_ack;
	logic        ln_scl;
	logic        ln_sda;
	logic        ln_oe;
	logic        ln_ack_bit;

	tick_t tick_queue[$];
	res_t  line_levels_exp[$];
	tick_t drv_item;
	logic  drv_hold;
	int    burst_left;
	int    gap_left;
	int    rx_stall;
	int    rx_cycle;

	int n_ticks;
	int n_checked;
	int n_done;
	int n_nack;
	int n_settings;
	int n_fail;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = ~clk;
	end

	task automatic arm(input ln_phase_t ph, input logic [15:0] ticks);
		ln_phase = ph;
		ln_timer = (ticks == 16'd0) ? 16'd1 : ticks;
	endtask

	task automatic open_stop();
		ln_scl = 1'b0;
		ln_sda = 1'b0;
		ln_oe  = 1'b1;
		arm(LN_STOP_A, cf_edge_hold);
	endtask

	task automatic step_line(input tick_t t, output res_t r);
		logic done;
		done = 1'b0;
		if (ln_phase == LN_IDLE) begin
			if (t.cmd_valid) begin
				case (t.req_type)
					REQ_START: begin
						ln_scl = 1'b1; ln_sda = 1'b1; ln_oe = 1'b1;
						arm(LN_START_A, cf_edge_hold);
					end
					REQ_WRITE: begin
						ln_shift = t.tx_byte; ln_bits = 4'd0;
						ln_scl = 1'b0; ln_sda = t.tx_byte[7]; ln_oe = 1'b1;
						arm(LN_WR_LO, cf_bit_half);
					end
					REQ_READ: begin
						ln_ack_bit = t.ack_value; ln_shift = 8'd0; ln_bits = 4'd0;
						ln_scl = 1'b0; ln_sda = 1'b1; ln_oe = 1'b0;
						arm(LN_RD_LO, cf_bit_half);
					end
					REQ_STOP: begin
						open_stop();
					end
				endcase
			end
		end else if (ln_phase == LN_ACK_WAIT) begin
			if (!t.sda_in) begin
				arm(LN_ACK_HOLD, cf_setup);
			end else begin
				ln_timer = ln_timer - 16'd1;
				if (ln_timer == 16'd0) begin
					ln_ack = 1'b0;
					n_nack++;
					open_stop();
				end
			end
		end else begin
			ln_timer = ln_timer - 16'd1;
			if (ln_timer == 16'd0) begin
				case (ln_phase)
					LN_START_A: begin
						ln_sda = 1'b0;
						arm(LN_START_B, cf_edge_hold);
					end
					LN_START_B: begin
						ln_scl = 1'b0;
						arm(LN_START_C, cf_edge_hold);
					end
					LN_START_C: begin
						ln_phase = LN_IDLE;
						done = 1'b1;
					end
					LN_WR_LO: begin
						ln_scl = 1'b1;
						arm(LN_WR_HI, cf_bit_half);
					end
					LN_WR_HI: begin
						ln_shift = ln_shift << 1;
						ln_bits = ln_bits + 4'd1;
						ln_scl = 1'b0;
						if (ln_bits < 4'd8) begin
							ln_sda = ln_shift[7];
							ln_oe = 1'b1;
							arm(LN_WR_LO, cf_bit_half);
						end else begin
							ln_oe = 1'b0;
							arm(LN_ACK_REL, cf_setup);
						end
					end
					LN_ACK_REL: begin
						ln_scl = 1'b1;
						arm(LN_ACK_WAIT, cf_ack_timeout);
					end
					LN_ACK_HOLD: begin
						ln_scl = 1'b0;
						ln_oe = 1'b1;
						arm(LN_ACK_END, cf_setup);
					end
					LN_ACK_END: begin
						ln_ack = 1'b1;
						ln_phase = LN_IDLE;
						done = 1'b1;
					end
					LN_RD_LO: begin
						ln_scl = 1'b1;
						arm(LN_RD_HI, cf_bit_half);
					end
					LN_RD_HI: begin
						ln_shift = {ln_shift[6:0], t.sda_in};
						ln_bits = ln_bits + 4'd1;
						ln_scl = 1'b0;
						if (ln_bits < 4'd8) begin
							arm(LN_RD_LO, cf_bit_half);
						end else begin
							ln_rx = ln_shift;
							ln_oe = 1'b1;
							ln_sda = ln_ack_bit;
							arm(LN_RACK_LO, cf_setup + cf_bit_half);
						end
					end
					LN_RACK_LO: begin
						if (ln_bits == 4'd8) begin
							ln_bits = 4'd9;
							ln_scl = 1'b1;
							arm(LN_RACK_HI, cf_bit_half);
						end else begin
							ln_phase = LN_IDLE;
							done = 1'b1;
						end
					end
					LN_RACK_HI: begin
						ln_scl = 1'b0;
						arm(LN_RACK_LO, cf_bit_half);
					end
					LN_STOP_A: begin
						ln_scl = 1'b1;
						arm(LN_STOP_B, cf_edge_hold);
					end
					LN_STOP_B: begin
						ln_sda = 1'b1;
						ln_phase = LN_IDLE;
						done = 1'b1;
					end
					default: begin
						ln_phase = LN_IDLE;
					end
				endcase
			end
		end
		if (done) begin
			n_done++;
		end
		r.scl_level = ln_scl;
		r.sda_level = ln_sda;
		r.sda_drive = ln_oe;
		r.busy_res  = (ln_phase != LN_IDLE);
		r.done_res  = done;
		r.rx_byte   = ln_rx;
		r.ack_ok    = ln_ack;
	endtask

	// driver: bursts of words with random gaps
	always @(negedge clk) begin
		if (!drv_hold) begin
			if (burst_left == 0 && gap_left == 0) begin
				gap_left = $urandom_range(0, 5);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
					: $urandom_range(1, 24);
			end
			if (gap_left != 0) begin
				gap_left--;
				cmd_ch.valid <= 1'b0;
			end else if (tick_queue.size() != 0) begin
				drv_item = tick_queue.pop_front();
				cmd_ch.cmd_valid <= drv_item.cmd_valid;
				cmd_ch.req_type  <= drv_item.req_type;
				cmd_ch.tx_byte   <= drv_item.tx_byte;
				cmd_ch.ack_value <= drv_item.ack_value;
				cmd_ch.sda_in    <= drv_item.sda_in;
				cmd_ch.valid     <= 1'b1;
				drv_hold = 1'b1;
				burst_left--;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : accept_word
		res_t pred;
		if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
			step_line(drv_item, pred);
			line_levels_exp.push_back(pred);
			drv_hold = 1'b0;
			n_ticks++;
		end
	end

	// receiver: short random stalls, with stall-free stretches
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 512 >= 384) begin
			res_ch.ready <= 1'b1;
		end else if (rx_stall != 0) begin
			res_ch.ready <= 1'b0;
			rx_stall--;
		end else begin
			res_ch.ready <= 1'b1;
			if ($urandom_range(0, 5) == 0) begin
				rx_stall = $urandom_range(1, 4);
			end
		end
	end

	task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin : monitor
		res_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (line_levels_exp.size() == 0) begin
				$error("result word with no prediction pending");
				n_fail++;
			end else begin
				want = line_levels_exp.pop_front();
				cmp_field("scl_level", 8'(want.scl_level), 8'(res_ch.scl_level));
				cmp_field("sda_level", 8'(want.sda_level), 8'(res_ch.sda_level));
				cmp_field("sda_drive", 8'(want.sda_drive), 8'(res_ch.sda_drive));
				cmp_field("busy_res", 8'(want.busy_res), 8'(res_ch.busy_res));
				cmp_field("done_res", 8'(want.done_res), 8'(res_ch.done_res));
				cmp_field("rx_byte", want.rx_byte, res_ch.rx_byte);
				cmp_field("ack_ok", 8'(want.ack_ok), 8'(res_ch.ack_ok));
				n_checked++;
			end
		end
	end

	task automatic push_tick(input logic valid, input req_t req, input logic [7:0] txb,
		input logic ackv, input logic sda);
		tick_t t;
		t.cmd_valid = valid;
		t.req_type  = req;
		t.tx_byte   = txb;
		t.ack_value = ackv;
		t.sda_in    = sda;
		tick_queue.push_back(t);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_BIT_HALF:    cf_bit_half    = {8'h00, val[7:0]};
			CFG_EDGE_HOLD:   cf_edge_hold   = {8'h00, val[7:0]};
			CFG_SETUP:       cf_setup       = {8'h00, val[7:0]};
			CFG_ACK_TIMEOUT: cf_ack_timeout = val;
		endcase
	endtask

	task automatic set_timing(input logic [7:0] bh, input logic [7:0] eh, input logic [7:0] su,
		input logic [15:0] to);
		write_reg(CFG_BIT_HALF, {8'($urandom_range(0, 255)), bh});
		write_reg(CFG_EDGE_HOLD, {8'($urandom_range(0, 255)), eh});
		write_reg(CFG_SETUP, {8'($urandom_range(0, 255)), su});
		write_reg(CFG_ACK_TIMEOUT, to);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic wait_quiet();
		while (tick_queue.size() != 0 || line_levels_exp.size() != 0 || drv_hold) begin
			@(negedge clk);
		end
	endtask

	// idle ticks with sda low until the sequencer is back in idle
	task automatic drain_to_idle();
		wait_quiet();
		while (ln_phase != LN_IDLE) begin
			repeat (64) push_tick(1'b0, REQ_START, 8'h00, 1'b0, 1'b0);
			wait_quiet();
		end
	endtask

	task automatic run_random(input int nticks);
		int   run_left;
		int   sda_mode;
		int   cmd_pct;
		int   k;
		logic sda_fix;
		logic sda;
		run_left = 0;
		sda_mode = 0;
		cmd_pct  = 0;
		sda_fix  = 1'b0;
		for (k = 0; k < nticks; k++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(1, 40);
				sda_mode = $urandom_range(0, 3);
				sda_fix  = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 3))
					0: cmd_pct = 0;
					1: cmd_pct = 10;
					default: cmd_pct = 40;
				endcase
			end
			run_left--;
			case (sda_mode)
				0: sda = 1'($urandom_range(0, 1));
				1: sda = ($urandom_range(0, 49) != 0);
				2: sda = ($urandom_range(0, 9) == 0);
				default: sda = sda_fix;
			endcase
			push_tick($urandom_range(0, 99) < cmd_pct, req_t'($urandom_range(0, 3)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
		end
		drain_to_idle();
	endtask

	initial begin : stimulus
		int i;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_BIT_HALF;
		cfg_data         = 16'd0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.cmd_valid = 1'b0;
		cmd_ch.req_type  = REQ_START;
		cmd_ch.tx_byte   = 8'd0;
		cmd_ch.ack_value = 1'b0;
		cmd_ch.sda_in    = 1'b1;
		res_ch.ready     = 1'b0;
		drv_item         = '0;
		drv_hold         = 1'b0;
		burst_left       = 0;
		gap_left         = 0;
		rx_stall         = 0;
		rx_cycle         = 0;
		n_ticks          = 0;
		n_checked        = 0;
		n_done           = 0;
		n_nack           = 0;
		n_settings       = 0;
		n_fail           = 0;

		cf_bit_half    = {8'h00, BIT_HALF_RST};
		cf_edge_hold   = {8'h00, EDGE_HOLD_RST};
		cf_setup       = {8'h00, SETUP_RST};
		cf_ack_timeout = ACK_TIMEOUT_RST;
		ln_phase   = LN_IDLE;
		ln_bits    = 4'd0;
		ln_timer   = 16'd0;
		ln_shift   = 8'd0;
		ln_rx      = 8'd0;
		ln_ack     = 1'b0;
		ln_scl     = 1'b1;
		ln_sda     = 1'b1;
		ln_oe      = 1'b1;
		ln_ack_bit = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero tick counts run as one tick
		set_timing(8'd0, 8'd0, 8'd0, 16'd5);
		// start, then writes offered while busy and on the completing tick
		push_tick(1'b1, REQ_START, 8'h00, 1'b0, 1'b1);
		repeat (3) push_tick(1'b1, REQ_WRITE, 8'h5a, 1'b0, 1'b1);
		push_tick(1'b1, REQ_WRITE, 8'hff, 1'b0, 1'b0);
		repeat (24) push_tick(1'b0, REQ_START, 8'h00, 1'b0, 1'b0);
		// no ack: timeout then stop
		push_tick(1'b1, REQ_WRITE, 8'h00, 1'b0, 1'b1);
		repeat (30) push_tick(1'b0, REQ_START, 8'h00, 1'b0, 1'b1);
		// ack arriving a few ticks into the wait
		push_tick(1'b1, REQ_WRITE, 8'h81, 1'b0, 1'b1);
		repeat (19) push_tick(1'b0, REQ_START, 8'h00, 1'b0, 1'b1);
		repeat (8) push_tick(1'b0, REQ_START, 8'h00, 1'b0, 1'b0);
		push_tick(1'b1, REQ_READ, 8'h00, 1'b0, 1'b1);
		repeat (24) push_tick(1'b0, REQ_READ, 8'h00, 1'b1, 1'b1);
		push_tick(1'b1, REQ_READ, 8'h00, 1'b1, 1'b0);
		repeat (24) push_tick(1'b0, REQ_READ, 8'h00, 1'b0, 1'b0);
		push_tick(1'b1, REQ_READ, 8'h00, 1'b0, 1'b1);
		for (i = 0; i < 24; i++) begin
			push_tick(1'b0, REQ_STOP, 8'h00, 1'b0, i[1]);
		end
		push_tick(1'b1, REQ_STOP, 8'h00, 1'b0, 1'b1);
		repeat (4) push_tick(1'b0, REQ_STOP, 8'h00, 1'b0, 1'b1);
		drain_to_idle();

		set_timing(BIT_HALF_RST, EDGE_HOLD_RST, SETUP_RST, ACK_TIMEOUT_RST);
		run_random(100);
		set_timing(8'd1, 8'd1, 8'd1, 16'd1);
		run_random(100);
		set_timing(8'd0, 8'd0, 8'd0, 16'd0);
		run_random(80);
		for (i = 0; i < 4; i++) begin
			set_timing(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
				8'($urandom_range(1, 6)), 16'($urandom_range(1, 24)));
			run_random(50);
		end
		set_timing(8'd2, 8'd1, 8'd255, 16'd3);
		run_random(30);

		wait_quiet();
		repeat (4) @(posedge clk);
		@(negedge clk);
		if (line_levels_exp.size() != 0) begin
			$error("%0d predicted words never arrived", line_levels_exp.size());
			n_fail++;
		end
		$display("tb_top: %0d ticks over %0d timing settings", n_ticks, n_settings);
		$display("tb_top: %0d commands completed, %0d ack timeouts", n_done, n_nack);
		$display("tb_top: %0d result words compared, %0d failures", n_checked, n_fail);
		if (n_fail == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
